FILE: rtl/core/ipcv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the address text validator.
// No dependencies; used by ipcv_front, ipcv_fifo, ipcv_back and the top level.
package ipcv_pkg;

    // Character classes decided by the front stage
    typedef enum logic [2:0] {
        CLS_DEC,
        CLS_HEX_ALPHA,
        CLS_COLON,
        CLS_SLASH,
        CLS_DOT,
        CLS_OTHER
    } char_class_t;

    // One classified character on its way to the back stage
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } char_item_t;

    // One verdict
    typedef struct packed {
        logic is_valid;
        logic colon_form;
    } verdict_t;

    // ASCII codes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    // Length and value limits
    localparam logic [5:0]  COUNT_SAT      = 6'd50;
    localparam logic [5:0]  MIN_LEN        = 6'd3;
    localparam logic [5:0]  MAX_LEN        = 6'd49;
    localparam logic [11:0] OCTET_MAX      = 12'd255;
    localparam logic [8:0]  OCTET_SAT      = 9'd256;
    localparam logic [2:0]  DIGIT_SAT      = 3'd4;
    localparam logic [2:0]  DIGIT_MAX      = 3'd3;
    localparam logic [2:0]  OCTETS_SAT     = 3'd7;
    localparam logic [2:0]  OCTETS_NEEDED  = 3'd4;
    localparam logic [8:0]  PREFIX_CLIP    = 9'd33;
    localparam logic [5:0]  PREFIX_SAT     = 6'd33;
    localparam logic [5:0]  PREFIX_MAX     = 6'd32;

    // Queue sizes
    localparam int MID_DEPTH = 4;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int OUT_DEPTH = 2;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

endpackage

FILE: rtl/core/ipcv_front.sv
`timescale 1ns / 1ps
// Front stage: register each accepted character with its class and digit value.
// Depends on ipcv_pkg.
module ipcv_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           char_code,
    input  logic                 last_char,
    input  logic                 mid_full,
    output logic                 stage_vld,
    output logic                 stage_move,
    output ipcv_pkg::char_item_t stage_item
);

    logic                 vld_reg, vld_next;
    ipcv_pkg::char_item_t item_reg;
    ipcv_pkg::char_class_t cls;

    always_comb
    begin
        case (char_code) inside
            [ipcv_pkg::CH_ZERO:ipcv_pkg::CH_NINE]:       cls = ipcv_pkg::CLS_DEC;
            [ipcv_pkg::CH_LOWER_A:ipcv_pkg::CH_LOWER_F],
            [ipcv_pkg::CH_UPPER_A:ipcv_pkg::CH_UPPER_F]: cls = ipcv_pkg::CLS_HEX_ALPHA;
            ipcv_pkg::CH_COLON:                          cls = ipcv_pkg::CLS_COLON;
            ipcv_pkg::CH_SLASH:                          cls = ipcv_pkg::CLS_SLASH;
            ipcv_pkg::CH_DOT:                            cls = ipcv_pkg::CLS_DOT;
            default:                                     cls = ipcv_pkg::CLS_OTHER;
        endcase
    end

    assign stage_move = vld_reg && !mid_full;
    assign vld_next   = take || (vld_reg && !stage_move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload: load on accept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cls   <= cls;
            item_reg.digit <= char_code[3:0];
            item_reg.last  <= last_char;
        end
    end

    assign stage_vld  = vld_reg;
    assign stage_item = item_reg;

endmodule

FILE: rtl/core/ipcv_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified characters between the front and back stages.
// Depends on ipcv_pkg.
module ipcv_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  ipcv_pkg::char_item_t wr_item,
    input  logic                 rd_en,
    output ipcv_pkg::char_item_t rd_item,
    output logic                 empty,
    output logic                 full
);

    ipcv_pkg::char_item_t        mem [ipcv_pkg::MID_DEPTH];
    logic [ipcv_pkg::MID_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ipcv_pkg::MID_AW:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (ipcv_pkg::MID_AW+1)'(ipcv_pkg::MID_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item = mem[rd_ptr_reg];

endmodule

FILE: rtl/core/ipcv_back.sv
`timescale 1ns / 1ps
// Back stage: per-string tracking of both address rules and the verdict queue.
// Depends on ipcv_pkg.
module ipcv_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  ipcv_pkg::char_item_t in_item,
    output logic                 in_take,
    input  logic                 pop,
    output logic                 empty,
    output logic                 is_valid,
    output logic                 colon_form
);

    logic [5:0] char_count_reg, char_count_next;
    logic       colon_seen_reg, colon_seen_next;
    logic       hex_bad_reg, hex_bad_next;
    logic       in_prefix_reg, in_prefix_next;
    logic [8:0] octet_val_reg, octet_val_next;
    logic [2:0] octet_digits_reg, octet_digits_next;
    logic       seg_start_reg, seg_start_next;
    logic       after_dot_reg, after_dot_next;
    logic [2:0] octets_reg, octets_next;
    logic [5:0] prefix_val_reg, prefix_val_next;
    logic       prefix_digit_reg, prefix_digit_next;
    logic       dotted_bad_reg, dotted_bad_next;

    logic [11:0] oct_wide;
    logic [8:0]  pfx_wide;
    logic        len_ok;
    ipcv_pkg::verdict_t verdict;

    ipcv_pkg::verdict_t        out_mem [ipcv_pkg::OUT_DEPTH];
    logic [ipcv_pkg::OUT_AW-1:0] out_wr_reg, out_rd_reg;
    logic [ipcv_pkg::OUT_AW:0]   out_cnt_reg, out_cnt_next;
    logic out_pop, out_push, out_room;

    assign out_pop  = pop && (out_cnt_reg != '0);
    assign out_room = (out_cnt_reg != (ipcv_pkg::OUT_AW+1)'(ipcv_pkg::OUT_DEPTH)) || out_pop;
    assign in_take  = in_vld && (!in_item.last || out_room);
    assign out_push = in_take && in_item.last;

    always_comb
    begin
        char_count_next   = char_count_reg;
        colon_seen_next   = colon_seen_reg;
        hex_bad_next      = hex_bad_reg;
        in_prefix_next    = in_prefix_reg;
        octet_val_next    = octet_val_reg;
        octet_digits_next = octet_digits_reg;
        seg_start_next    = seg_start_reg;
        after_dot_next    = after_dot_reg;
        octets_next       = octets_reg;
        prefix_val_next   = prefix_val_reg;
        prefix_digit_next = prefix_digit_reg;
        dotted_bad_next   = dotted_bad_reg;
        oct_wide = (12'(octet_val_reg) << 3) + (12'(octet_val_reg) << 1) + 12'(in_item.digit);
        pfx_wide = (9'(prefix_val_reg) << 3) + (9'(prefix_val_reg) << 1) + 9'(in_item.digit);
        len_ok   = 1'b0;
        verdict  = '0;

        if (char_count_reg < ipcv_pkg::COUNT_SAT)
        begin
            char_count_next = char_count_reg + 1'b1;
        end
        if (in_item.cls == ipcv_pkg::CLS_COLON)
        begin
            colon_seen_next = 1'b1;
        end
        if (in_item.cls == ipcv_pkg::CLS_DOT || in_item.cls == ipcv_pkg::CLS_OTHER)
        begin
            hex_bad_next = 1'b1;
        end

        if (in_prefix_reg)
        begin
            if (in_item.cls == ipcv_pkg::CLS_DEC)
            begin
                prefix_val_next   = (pfx_wide > ipcv_pkg::PREFIX_CLIP) ?
                                    ipcv_pkg::PREFIX_SAT : pfx_wide[5:0];
                prefix_digit_next = 1'b1;
            end
            else
            begin
                dotted_bad_next = 1'b1;
            end
        end
        else
        begin
            unique case (in_item.cls)
                ipcv_pkg::CLS_DEC:
                begin
                    if (oct_wide > ipcv_pkg::OCTET_MAX)
                    begin
                        octet_val_next  = ipcv_pkg::OCTET_SAT;
                        dotted_bad_next = 1'b1;
                    end
                    else
                    begin
                        octet_val_next = oct_wide[8:0];
                    end
                    if (octet_digits_reg < ipcv_pkg::DIGIT_SAT)
                    begin
                        octet_digits_next = octet_digits_reg + 1'b1;
                    end
                    seg_start_next = 1'b0;
                    after_dot_next = 1'b0;
                end
                ipcv_pkg::CLS_DOT:
                begin
                    if (seg_start_reg || octet_digits_reg > ipcv_pkg::DIGIT_MAX)
                    begin
                        dotted_bad_next = 1'b1;
                    end
                    if (octets_reg < ipcv_pkg::OCTETS_SAT)
                    begin
                        octets_next = octets_reg + 1'b1;
                    end
                    octet_val_next    = '0;
                    octet_digits_next = '0;
                    seg_start_next    = 1'b1;
                    after_dot_next    = 1'b1;
                end
                ipcv_pkg::CLS_SLASH:
                begin
                    if (!seg_start_reg)
                    begin
                        if (octet_digits_reg > ipcv_pkg::DIGIT_MAX)
                        begin
                            dotted_bad_next = 1'b1;
                        end
                        if (octets_reg < ipcv_pkg::OCTETS_SAT)
                        begin
                            octets_next = octets_reg + 1'b1;
                        end
                        octet_val_next    = '0;
                        octet_digits_next = '0;
                        seg_start_next    = 1'b1;
                    end
                    else if (!after_dot_reg)
                    begin
                        dotted_bad_next = 1'b1;
                    end
                    if (octets_next != ipcv_pkg::OCTETS_NEEDED)
                    begin
                        dotted_bad_next = 1'b1;
                    end
                    after_dot_next = 1'b0;
                    in_prefix_next = 1'b1;
                end
                default:
                begin
                    dotted_bad_next = 1'b1;
                    after_dot_next  = 1'b0;
                end
            endcase
        end

        // Final checks on the last character
        if (in_item.last)
        begin
            if (in_prefix_next)
            begin
                if (!prefix_digit_next || prefix_val_next > ipcv_pkg::PREFIX_MAX)
                begin
                    dotted_bad_next = 1'b1;
                end
            end
            else
            begin
                if (seg_start_next || octet_digits_next > ipcv_pkg::DIGIT_MAX)
                begin
                    dotted_bad_next = 1'b1;
                end
                if (octets_next < ipcv_pkg::OCTETS_SAT)
                begin
                    octets_next = octets_next + 1'b1;
                end
                if (octets_next != ipcv_pkg::OCTETS_NEEDED)
                begin
                    dotted_bad_next = 1'b1;
                end
            end
            len_ok = (char_count_next >= ipcv_pkg::MIN_LEN) &&
                     (char_count_next <= ipcv_pkg::MAX_LEN);
            verdict.colon_form = colon_seen_next;
            verdict.is_valid   = len_ok && (colon_seen_next ? !hex_bad_next : !dotted_bad_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg   <= '0;
            colon_seen_reg   <= 1'b0;
            hex_bad_reg      <= 1'b0;
            in_prefix_reg    <= 1'b0;
            octet_val_reg    <= '0;
            octet_digits_reg <= '0;
            seg_start_reg    <= 1'b1;
            after_dot_reg    <= 1'b0;
            octets_reg       <= '0;
            prefix_val_reg   <= '0;
            prefix_digit_reg <= 1'b0;
            dotted_bad_reg   <= 1'b0;
        end
        else if (in_take && in_item.last)
        begin
            // Verdict given: start afresh for the next string
            char_count_reg   <= '0;
            colon_seen_reg   <= 1'b0;
            hex_bad_reg      <= 1'b0;
            in_prefix_reg    <= 1'b0;
            octet_val_reg    <= '0;
            octet_digits_reg <= '0;
            seg_start_reg    <= 1'b1;
            after_dot_reg    <= 1'b0;
            octets_reg       <= '0;
            prefix_val_reg   <= '0;
            prefix_digit_reg <= 1'b0;
            dotted_bad_reg   <= 1'b0;
        end
        else if (in_take)
        begin
            char_count_reg   <= char_count_next;
            colon_seen_reg   <= colon_seen_next;
            hex_bad_reg      <= hex_bad_next;
            in_prefix_reg    <= in_prefix_next;
            octet_val_reg    <= octet_val_next;
            octet_digits_reg <= octet_digits_next;
            seg_start_reg    <= seg_start_next;
            after_dot_reg    <= after_dot_next;
            octets_reg       <= octets_next;
            prefix_val_reg   <= prefix_val_next;
            prefix_digit_reg <= prefix_digit_next;
            dotted_bad_reg   <= dotted_bad_next;
        end
    end

    // Verdict queue
    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (out_push && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
        else if (out_pop && !out_push)
        begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (out_push)
            begin
                out_wr_reg <= out_wr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_mem[out_wr_reg] <= verdict;
        end
    end

    assign empty      = (out_cnt_reg == '0);
    assign is_valid   = out_mem[out_rd_reg].is_valid;
    assign colon_form = out_mem[out_rd_reg].colon_form;

endmodule

FILE: rtl/core/ip_or_cidr_text_validator.sv
`timescale 1ns / 1ps
// Top level of the address text validator.
// Depends on ipcv_pkg, ipcv_front, ipcv_fifo and ipcv_back.
//
// Usage
//   Input queue: drive char_code and last_char, raise push; a character item
//   is taken at a rising edge with push high and full low. Mark the final
//   character of each string with last_char.
//   Result queue: while empty is low, is_valid and colon_form show the oldest
//   verdict; raise pop to take it. One verdict per string, none otherwise.
// Throughput: one character item per clock, sustained, while verdicts are
//   drained; the back stage updates its per-string tracking as it takes each character.
// Path: after its last character is taken, a verdict passes the front
//   register, then the character queue and the back-stage update, into the
//   verdict queue, where it becomes visible.
// Stall: when pop is held low the verdict queue (two entries) fills, the back
//   stage holds at the next last character, the four-entry character queue
//   fills behind it and full rises; nothing is lost or repeated.
// Reset: rst_n clears all queues and the per-string tracking; empty is high
//   and full low straight away, no clearing pass is needed.
module ip_or_cidr_text_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       empty,
    input  logic       pop,
    output logic       is_valid,
    output logic       colon_form
);

    logic                 take;
    logic                 stage_vld, stage_move;
    ipcv_pkg::char_item_t stage_item;
    ipcv_pkg::char_item_t mid_item;
    logic                 mid_empty, mid_full;
    logic                 back_take;

    // Hold off new characters only when the front register cannot move on
    assign full = stage_vld && mid_full;
    assign take = push && !full;

    ipcv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .char_code  (char_code),
        .last_char  (last_char),
        .mid_full   (mid_full),
        .stage_vld  (stage_vld),
        .stage_move (stage_move),
        .stage_item (stage_item)
    );

    ipcv_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (stage_move),
        .wr_item (stage_item),
        .rd_en   (back_take),
        .rd_item (mid_item),
        .empty   (mid_empty),
        .full    (mid_full)
    );

    ipcv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (!mid_empty),
        .in_item    (mid_item),
        .in_take    (back_take),
        .pop        (pop),
        .empty      (empty),
        .is_valid   (is_valid),
        .colon_form (colon_form)
    );

endmodule

FILE: rtl/core/ipcv_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the address text validator, bound to the top level.
// Depends on ip_or_cidr_text_validator.
module ipcv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       is_valid,
    input logic       colon_form
);

    // Reset leaves both queues open and empty
    a_reset_state: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // Back-pressure only builds up from accepted characters
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose with no character pushed");

    // A waiting verdict holds until taken
    a_verdict_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(is_valid) && $stable(colon_form)))
        else $error("waiting verdict changed or vanished");

endmodule

bind ip_or_cidr_text_validator ipcv_checker u_ipcv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .is_valid   (is_valid),
    .colon_form (colon_form)
);
